[sv/four_channel_servo_pulse_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Servo pulse sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_SERVO_PULSE_SEQUENCER_DEFINES_SVH
`define FOUR_CHANNEL_SERVO_PULSE_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FCSPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FCSPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fcsps_pkg.sv]
// ----------------------------------------------------------------------------
// Servo pulse sequencer package
// Widths, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcsps_pkg;

  localparam int PIN_W     = 4;
  localparam int POS_W     = 8;
  localparam int CMP_W     = 8;
  localparam int PHASE_W   = 8;
  localparam int BUDGET_W  = 16;
  localparam int RELOAD_W  = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;
  localparam int IN_DAT_W  = 8;
  localparam int OUT_DAT_W = 16;

  typedef logic [7:0] cmd_t;

  localparam cmd_t CMD_STEP_UP     = 8'h10;
  localparam cmd_t CMD_STEP_DOWN   = 8'h11;
  localparam cmd_t CMD_PRESET_LOW  = 8'h01;
  localparam cmd_t CMD_PRESET_HIGH = 8'h02;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_MIN_PULSE    = 3'd0;
  localparam reg_idx_t REG_GAP_INTERVAL = 3'd1;
  localparam reg_idx_t REG_FRAME_RELOAD = 3'd2;
  localparam reg_idx_t REG_STEP_SIZE    = 3'd3;
  localparam reg_idx_t REG_PRESET_LOW   = 3'd4;
  localparam reg_idx_t REG_PRESET_HIGH  = 3'd5;

  localparam logic [CMP_W-1:0]    MIN_PULSE_RST    = 8'd250;
  localparam logic [CMP_W-1:0]    GAP_INTERVAL_RST = 8'd100;
  localparam logic [RELOAD_W-1:0] FRAME_RELOAD_RST = 15'd4750;
  localparam logic [POS_W-1:0]    STEP_SIZE_RST    = 8'd2;
  localparam logic [POS_W-1:0]    PRESET_LOW_RST   = 8'd25;
  localparam logic [POS_W-1:0]    PRESET_HIGH_RST  = 8'd200;
  localparam logic [CMP_W-1:0]    COMPARE_RST      = 8'd100;
  localparam logic [BUDGET_W-1:0] BUDGET_RST       = 16'd5000;
  localparam logic [POS_W-1:0]    POSITION_RST     = 8'd120;

  localparam logic [OUT_DAT_W-PIN_W-POS_W-1:0] OUT_PAD = '0;

endpackage

[sv/four_channel_servo_pulse_sequencer.sv]
// ----------------------------------------------------------------------------
// Four channel servo pulse sequencer
// Counts timer ticks against a compare value and steps a pulse phase that
// drives the servo pins; remote commands move or preset all positions.
// ----------------------------------------------------------------------------
// Output: a result appears on out_* in the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; the state
// registers take their next value in the same cycle the item is accepted, and
// the result register is refilled while the previous result is taken.
// Reset: synchronous, active low on rst_n; clears all state and config, except
// the result data register, to their power-up values.
`timescale 1ns / 1ps
`include "four_channel_servo_pulse_sequencer_defines.svh"

module four_channel_servo_pulse_sequencer #(
  parameter int SERVO_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fcsps_pkg::IN_DAT_W-1:0]      in_tdata,   // [7:0] command_code
  input  logic [0:0]                          in_tuser,   // [0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fcsps_pkg::OUT_DAT_W-1:0]     out_tdata,  // [3:0] servo_pins,
                                                          // [11:4] channel0_position
  input  logic                                cfg_we,
  input  logic [fcsps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcsps_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int PW = fcsps_pkg::PIN_W;
  localparam int QW = fcsps_pkg::POS_W;
  localparam int CW = fcsps_pkg::CMP_W;
  localparam int HW = fcsps_pkg::PHASE_W;
  localparam int BW = fcsps_pkg::BUDGET_W;
  localparam int RW = fcsps_pkg::RELOAD_W;

  localparam logic [HW-1:0] LAST_PHASE = HW'(2 * SERVO_COUNT);
  localparam logic [HW-2:0] SERVO_K    = (HW-1)'(SERVO_COUNT);
  localparam logic [PW-1:0] PIN_USED   = PW'((1 << SERVO_COUNT) - 1);
  localparam logic [PW-1:0] LAST_PIN   = PW'(1 << (SERVO_COUNT - 1));

  typedef logic [SERVO_COUNT-1:0][QW-1:0] pos_vec_t;

  // Configuration registers
  logic [CW-1:0] min_pulse_r;
  logic [CW-1:0] gap_interval_r;
  logic [RW-1:0] frame_reload_r;
  logic [QW-1:0] step_size_r;
  logic [QW-1:0] preset_low_r;
  logic [QW-1:0] preset_high_r;

  // Sequencer state
  logic [CW-1:0] tick_count_r, tick_count_nxt;
  logic [CW-1:0] compare_r, compare_nxt;
  logic [HW-1:0] phase_r, phase_nxt;
  logic [BW-1:0] budget_r, budget_nxt;
  pos_vec_t      pos_r, pos_nxt;
  logic [PW-1:0] pin_levels_r, pin_levels_nxt;

  logic                     out_tvalid_r;
  logic [fcsps_pkg::OUT_DAT_W-1:0] out_tdata_r;

  logic          in_acc;
  logic          is_cmd;
  logic          at_match;
  logic [HW-2:0] k;
  logic [QW-1:0] pos_sel;
  logic [PW-1:0] pair_mask;
  logic [BW-1:0] budget_base;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign is_cmd     = in_tuser[0];
  assign at_match   = (tick_count_r == compare_r);
  assign k          = phase_r[HW-1:1];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Position picked by odd phases and the pin pair handed over by even ones.
  always_comb begin
    pos_sel   = '0;
    pair_mask = '0;
    for (int i = 0; i < SERVO_COUNT; i++) begin
      if (k == (HW-1)'(i)) begin
        pos_sel = pos_r[i];
      end
    end
    for (int i = 0; i < PW; i++) begin
      pair_mask[i] = (k == (HW-1)'(i)) || (k == (HW-1)'(i + 1));
    end
  end

  always_comb begin
    tick_count_nxt = tick_count_r;
    compare_nxt    = compare_r;
    phase_nxt      = phase_r;
    pin_levels_nxt = pin_levels_r;
    pos_nxt        = pos_r;
    budget_base    = budget_r;
    budget_nxt     = budget_r;
    if (!is_cmd) begin
      if (at_match) begin
        tick_count_nxt = '0;
        phase_nxt      = phase_r + HW'(1);
        if (phase_r <= LAST_PHASE) begin
          if (phase_r[0]) begin
            compare_nxt = pos_sel;
          end else if (k == '0) begin
            pin_levels_nxt = pin_levels_r | PW'(1);
            compare_nxt    = min_pulse_r;
          end else if (k < SERVO_K) begin
            pin_levels_nxt = pin_levels_r ^ (pair_mask & PIN_USED);
            compare_nxt    = min_pulse_r;
          end else begin
            pin_levels_nxt = pin_levels_r ^ LAST_PIN;
            compare_nxt    = gap_interval_r;
          end
        end else if (budget_r[BW-1]) begin
          // Frame is used up: restart the pulse train with a fresh budget.
          phase_nxt   = '0;
          budget_base = {1'b0, frame_reload_r};
        end
        budget_nxt = budget_base - {{(BW-CW){1'b0}}, compare_nxt};
      end else begin
        tick_count_nxt = tick_count_r + CW'(1);
      end
    end else begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        case (in_tdata)
          fcsps_pkg::CMD_STEP_UP:     pos_nxt[i] = pos_r[i] + step_size_r;
          fcsps_pkg::CMD_STEP_DOWN:   pos_nxt[i] = pos_r[i] - step_size_r;
          fcsps_pkg::CMD_PRESET_LOW:  pos_nxt[i] = preset_low_r;
          fcsps_pkg::CMD_PRESET_HIGH: pos_nxt[i] = preset_high_r;
          default:                    pos_nxt[i] = pos_r[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r    <= fcsps_pkg::MIN_PULSE_RST;
      gap_interval_r <= fcsps_pkg::GAP_INTERVAL_RST;
      frame_reload_r <= fcsps_pkg::FRAME_RELOAD_RST;
      step_size_r    <= fcsps_pkg::STEP_SIZE_RST;
      preset_low_r   <= fcsps_pkg::PRESET_LOW_RST;
      preset_high_r  <= fcsps_pkg::PRESET_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcsps_pkg::REG_MIN_PULSE:    min_pulse_r    <= cfg_data[CW-1:0];
        fcsps_pkg::REG_GAP_INTERVAL: gap_interval_r <= cfg_data[CW-1:0];
        fcsps_pkg::REG_FRAME_RELOAD: frame_reload_r <= cfg_data[RW-1:0];
        fcsps_pkg::REG_STEP_SIZE:    step_size_r    <= cfg_data[QW-1:0];
        fcsps_pkg::REG_PRESET_LOW:   preset_low_r   <= cfg_data[QW-1:0];
        fcsps_pkg::REG_PRESET_HIGH:  preset_high_r  <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      compare_r    <= fcsps_pkg::COMPARE_RST;
      phase_r      <= '0;
      budget_r     <= fcsps_pkg::BUDGET_RST;
      pos_r        <= {SERVO_COUNT{fcsps_pkg::POSITION_RST}};
      pin_levels_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        tick_count_r <= tick_count_nxt;
        compare_r    <= compare_nxt;
        phase_r      <= phase_nxt;
        budget_r     <= budget_nxt;
        pos_r        <= pos_nxt;
        pin_levels_r <= pin_levels_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // The result register holds its transfer until it is taken.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {fcsps_pkg::OUT_PAD, pos_nxt[0], pin_levels_nxt};
    end
  end

  `FCSPS_ASSERT_NEXT(a_tick_advance, in_acc && !is_cmd && !at_match,
    tick_count_r == $past(tick_count_r) + CW'(1), "tick counter did not advance")
  `FCSPS_ASSERT_NEXT(a_cmd_keeps_timer, in_acc && is_cmd,
    $stable(tick_count_r) && $stable(phase_r) && $stable(budget_r),
    "command disturbed the timer state")
  `FCSPS_ASSERT_NOW(a_unused_pins_low, 1'b1, (pin_levels_r & ~PIN_USED) == '0,
    "pin beyond the servo count driven")
  `FCSPS_ASSERT_NEXT(a_result_follows_transfer, in_acc, out_tvalid_r,
    "accepted item produced no result")

endmodule
